[src/sfcp_pkg.sv]
// Shared types and constants for the serial command frame parser.
// No dependencies; imported by the control unit and the top level.
package sfcp_pkg;

  localparam int DEF_STORE_DEPTH = 256;
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int ENTRY_CAP       = 16;

  localparam logic [7:0] BYTE_MARK  = 8'h84;
  localparam logic [7:0] BYTE_END   = 8'hF1;
  localparam logic [7:0] BYTE_START = 8'hF0;
  localparam logic [7:0] CMD_TIME   = 8'h81;
  localparam logic [7:0] CMD_SCHED  = 8'h82;
  localparam logic [7:0] CMD_LINK   = 8'h83;
  localparam logic [7:0] ARG_LINK   = 8'h80;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_WT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_TIME,
    PH_ENTRY
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TIME  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_LINK  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value_0;
    logic [7:0] value_1;
    logic [7:0] value_2;
    logic [7:0] value_3;
    logic [7:0] value_4;
    logic [7:0] value_5;
    logic [3:0] entry_index;
    logic       truncated;
    logic       last;
  } result_t;

endpackage

[src/sfcp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sfcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/sfcp_ctrl.sv]
// Control unit: fill count, end-marker detection, start-pair scan and command decode.
// Depends on sfcp_pkg; drives the ports of one sfcp_ram instance.
module sfcp_ctrl
  import sfcp_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_rx_byte,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata,
  input  logic          slot_free,
  output logic          res_load,
  output result_t       res
);

  localparam int LIMIT = (MAX_ENTRIES < ENTRY_CAP) ? MAX_ENTRIES : ENTRY_CAP;
  localparam int RW    = $clog2(LIMIT + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  kind_t           ek_r, ek_nxt;
  logic [AW-1:0]   fc_r, fc_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [AW-1:0]   lim_r, lim_nxt;
  logic [AW-1:0]   iss_r, iss_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic            rv_r, rv_nxt;
  logic [7:0]      last_r, last_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [2:0]      gcnt_r, gcnt_nxt;
  logic [6:0][7:0] sh_r, sh_nxt;
  logic [7:0]      decl_r, decl_nxt;
  logic            tr_r, tr_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [3:0]      idx_r, idx_nxt;

  logic          in_acc;
  logic [AW-1:0] fc_inc;
  logic          detect;
  logic          scan_hit;
  logic          scan_end;
  logic          head_time;
  logic          head_emit;
  logic          decl_over;

  assign in_acc    = in_valid && in_ready;
  assign fc_inc    = (fc_r == LAST_ADDR) ? '0 : fc_r + 1'b1;
  assign detect    = in_acc && (fc_inc >= AW'(4)) && (prev_r == BYTE_MARK) &&
                     (in_rx_byte == BYTE_END);
  // A start pair needs a valid previous byte, so position zero never closes one.
  assign scan_hit  = rv_r && (cur_r != '0) && (last_r == BYTE_MARK) &&
                     (mem_rdata == BYTE_START);
  assign scan_end  = rv_r && (scan_hit || (cur_r == lim_r));
  assign head_time = (sh_r[6] == CMD_TIME);
  assign head_emit = (sh_r[6] == CMD_SCHED) ||
                     ((sh_r[6] == CMD_LINK) && (mem_rdata == ARG_LINK));
  assign decl_over = (mem_rdata > 8'(LIMIT));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (clr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (detect) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_WT;
      end
      ST_WT: begin
        if (gcnt_r == 3'd1) begin
          if (phase_r != PH_HEAD) begin
            state_nxt = ST_EMIT;
          end else if (head_time) begin
            state_nxt = ST_RD;
          end else if (head_emit) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (ek_r == KIND_COUNT && rem_r != '0) begin
            state_nxt = ST_RD;
          end else if (ek_r == KIND_ENTRY && rem_r != RW'(1)) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = fc_r;
    mem_wdata = in_rx_byte;
    mem_raddr = (state_r == ST_SCAN) ? iss_r : rp_r;
    res_load  = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_we = in_acc;
      end
      ST_EMIT: begin
        res_load = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    res = '0;
    res.kind = ek_r;
    unique case (ek_r)
      KIND_TIME: begin
        res.value_0 = sh_r[1];
        res.value_1 = sh_r[2];
        res.value_2 = sh_r[3];
        res.value_3 = sh_r[4];
        res.value_4 = sh_r[5];
        res.value_5 = sh_r[6];
        res.last    = 1'b1;
      end
      KIND_COUNT: begin
        res.value_0   = decl_r;
        res.truncated = tr_r;
        res.last      = (rem_r == '0);
      end
      KIND_ENTRY: begin
        res.value_0     = sh_r[4];
        res.value_1     = sh_r[5];
        res.value_2     = {4'h0, sh_r[6][3:0]};
        res.value_3     = {4'h0, sh_r[6][7:4]};
        res.entry_index = idx_r;
        res.truncated   = tr_r;
        res.last        = (rem_r == RW'(1));
      end
      KIND_LINK: begin
        res.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    fc_nxt    = fc_r;
    clr_nxt   = clr_r;
    lim_nxt   = lim_r;
    iss_nxt   = iss_r;
    cur_nxt   = cur_r;
    rv_nxt    = rv_r;
    last_nxt  = last_r;
    prev_nxt  = prev_r;
    rp_nxt    = rp_r;
    gcnt_nxt  = gcnt_r;
    sh_nxt    = sh_r;
    decl_nxt  = decl_r;
    tr_nxt    = tr_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    ek_nxt    = ek_r;
    unique case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          prev_nxt = in_rx_byte;
          fc_nxt   = detect ? '0 : fc_inc;
          lim_nxt  = fc_inc - AW'(2);
          iss_nxt  = '0;
          rv_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        iss_nxt  = iss_r + 1'b1;
        cur_nxt  = iss_r;
        rv_nxt   = 1'b1;
        if (rv_r) last_nxt = mem_rdata;
        if (scan_end) begin
          // Command byte sits two past the start; no wrap is possible here.
          rp_nxt    = scan_hit ? cur_r + 1'b1 : lim_r + AW'(2);
          phase_nxt = PH_HEAD;
          gcnt_nxt  = 3'd2;
        end
      end
      ST_RD: ;
      ST_WT: begin
        sh_nxt   = {mem_rdata, sh_r[6:1]};
        rp_nxt   = (rp_r == LAST_ADDR) ? '0 : rp_r + 1'b1;
        gcnt_nxt = gcnt_r - 1'b1;
        if (gcnt_r == 3'd1) begin
          unique case (phase_r)
            PH_HEAD: begin
              decl_nxt = mem_rdata;
              tr_nxt   = decl_over;
              rem_nxt  = decl_over ? RW'(LIMIT) : RW'(mem_rdata);
              idx_nxt  = '0;
              if (head_time) begin
                phase_nxt = PH_TIME;
                gcnt_nxt  = 3'd5;
              end else if (sh_r[6] == CMD_SCHED) begin
                ek_nxt = KIND_COUNT;
              end else begin
                ek_nxt = KIND_LINK;
              end
            end
            PH_TIME: ek_nxt = KIND_TIME;
            PH_ENTRY: ek_nxt = KIND_ENTRY;
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          phase_nxt = PH_ENTRY;
          gcnt_nxt  = 3'd3;
          if (ek_r == KIND_ENTRY) begin
            rem_nxt = rem_r - 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      phase_r <= PH_HEAD;
      ek_r    <= KIND_TIME;
      fc_r    <= '0;
      clr_r   <= '0;
      lim_r   <= '0;
      iss_r   <= '0;
      cur_r   <= '0;
      rv_r    <= 1'b0;
      gcnt_r  <= '0;
      rem_r   <= '0;
      idx_r   <= '0;
      rp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ek_r    <= ek_nxt;
      fc_r    <= fc_nxt;
      clr_r   <= clr_nxt;
      lim_r   <= lim_nxt;
      iss_r   <= iss_nxt;
      cur_r   <= cur_nxt;
      rv_r    <= rv_nxt;
      gcnt_r  <= gcnt_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
      rp_r    <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    prev_r <= prev_nxt;
    sh_r   <= sh_nxt;
    decl_r <= decl_nxt;
    tr_r   <= tr_nxt;
  end

  a_fc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    detect |=> (fc_r == '0))
    else $error("fill count not cleared after end marker");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && rv_r) |-> (cur_r <= lim_r))
    else $error("scan ran past the end marker");

  a_rem_limit: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= RW'(LIMIT))
    else $error("entry count above limit");

  a_entry_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && ek_r == KIND_ENTRY) |-> (rem_r != '0))
    else $error("entry emitted with none remaining");

endmodule

[src/serial_command_frame_parser_top.sv]
// Top level of the serial command frame parser: byte store, control unit, result register.
// Depends on sfcp_pkg, sfcp_ram and sfcp_ctrl.

// Each received word is accepted only while the control unit is idle and is written into
// the frame store at the fill count. A word that completes the 84 F1 end marker (with at
// least four words held) starts a scan of the store from position zero for the first 84 F0
// start pair, one position a cycle; the command is then read back from the store, each word
// through a read state and a wait state (7 words for set time, 2 + 3n for a schedule of n
// entries), and each result is loaded into the result register once that register is free.
// After reset the block sweeps every position of the store to zero before in_ready first
// rises.
module serial_command_frame_parser_top
  import sfcp_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_value_0,
  output logic [7:0] out_value_1,
  output logic [7:0] out_value_2,
  output logic [7:0] out_value_3,
  output logic [7:0] out_value_4,
  output logic [7:0] out_value_5,
  output logic [3:0] out_entry_index,
  output logic       out_truncated,
  output logic       out_last
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          slot_free;
  logic          res_load;
  result_t       res;

  logic    out_valid_r, out_valid_nxt;
  result_t out_r;

  sfcp_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  sfcp_ctrl #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res       (res)
  );

  // The result register frees up in the same cycle its word is taken.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_r.kind;
  assign out_value_0     = out_r.value_0;
  assign out_value_1     = out_r.value_1;
  assign out_value_2     = out_r.value_2;
  assign out_value_3     = out_r.value_3;
  assign out_value_4     = out_r.value_4;
  assign out_value_5     = out_r.value_5;
  assign out_entry_index = out_r.entry_index;
  assign out_truncated   = out_r.truncated;
  assign out_last        = out_r.last;

endmodule
